### rtl/filtered_message_queue_macros.svh
// Assertion helpers for the message queue.
`ifndef FILTERED_MESSAGE_QUEUE_MACROS_SVH
`define FILTERED_MESSAGE_QUEUE_MACROS_SVH

// Property that holds every clock outside reset.
`define FMQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked only when reset was also released at the prior sample.
`define FMQ_ASSERT_PAST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		$past(arst_n) |-> (prop)) else $error(msg);

`endif

### rtl/fmq_pkg.sv
package fmq_pkg;

	localparam int QueueDepth = 64;
	localparam int IdxW       = $clog2(QueueDepth);
	localparam int CntW       = $clog2(QueueDepth + 1);
	localparam int EntryW     = 7 * 32;

	localparam logic [31:0] CodeQuit   = 32'h0000_0012;
	localparam logic [31:0] CodeMove   = 32'h0000_0200;
	localparam logic [31:0] CodeLDown  = 32'h0000_0201;
	localparam logic [31:0] CodeLUp    = 32'h0000_0202;
	localparam logic [31:0] CodeRDown  = 32'h0000_0204;
	localparam logic [31:0] CodeRUp    = 32'h0000_0205;
	localparam logic [31:0] CodeMDown  = 32'h0000_0207;
	localparam logic [31:0] CodeMUp    = 32'h0000_0208;
	localparam logic [4:0]  FlagLeft   = 5'h01;
	localparam logic [4:0]  FlagRight  = 5'h02;
	localparam logic [4:0]  FlagMiddle = 5'h10;
	localparam logic [31:0] WinAllOnes = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_POST    = 3'd0,
		OP_QUIT    = 3'd1,
		OP_MOVE    = 3'd2,
		OP_PRESS   = 3'd3,
		OP_RELEASE = 3'd4,
		OP_PEEK    = 3'd5,
		OP_TAKE    = 3'd6,
		OP_NONE    = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		BTN_LEFT    = 2'd0,
		BTN_RIGHT   = 2'd1,
		BTN_MIDDLE  = 2'd2,
		BTN_INVALID = 2'd3
	} btn_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAIL,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] window_handle;
		logic [31:0] message_code;
		logic [31:0] word_param;
		logic [31:0] long_param;
		logic [31:0] event_time;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0] code_lo;
		logic [31:0] code_hi;
		logic [1:0]  button_index;
		logic [31:0] button_mask;
	} in_item_t;

	typedef struct packed {
		logic        success;
		logic [31:0] out_window;
		logic [31:0] out_code;
		logic [31:0] out_word;
		logic [31:0] out_long;
		logic [31:0] out_time;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
	} out_item_t;

	typedef struct packed {
		logic [31:0] win;
		logic [31:0] code;
		logic [31:0] word;
		logic [31:0] lng;
		logic [31:0] tim;
		logic [31:0] sx;
		logic [31:0] sy;
	} entry_t;

	typedef struct packed {
		logic            we;
		logic [IdxW-1:0] waddr;
		entry_t          wdata;
		logic [IdxW-1:0] raddr;
	} mem_req_t;

	function automatic logic entry_match(entry_t e, logic [31:0] win,
			logic [31:0] lo, logic [31:0] hi);
		logic win_ok;
		begin
			if (win == WinAllOnes)
				win_ok = (e.win == 32'd0);
			else
				win_ok = (win == 32'd0) || (e.win == win);
			if (e.code == CodeQuit)
				entry_match = 1'b1;
			else if (!win_ok)
				entry_match = 1'b0;
			else if (lo == 32'd0 && hi == 32'd0)
				entry_match = 1'b1;
			else
				entry_match = (e.code >= lo) && (e.code <= hi);
		end
	endfunction

endpackage

### rtl/fmq_ram.sv
module fmq_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### rtl/fmq_ctrl.sv
module fmq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  fmq_pkg::in_item_t     in_item,
	output logic                  in_ready,
	output logic                  res_valid,
	output fmq_pkg::out_item_t    res_item,
	input  logic                  res_taken,
	output fmq_pkg::mem_req_t     mem_req,
	input  fmq_pkg::entry_t       mem_rdata,
	output logic [fmq_pkg::CntW-1:0] count
);

	fmq_pkg::state_t state_q, state_d;
	fmq_pkg::in_item_t item_q;
	logic [fmq_pkg::CntW-1:0] count_q, count_d;
	logic [fmq_pkg::CntW-1:0] ptr_q, ptr_d;
	logic quit_q, quit_d;
	logic [4:0] btn_q, btn_d;
	fmq_pkg::out_item_t res_q, res_d;

	logic full;
	fmq_pkg::entry_t new_e;
	logic [4:0] flag;
	logic [31:0] bcode;
	logic [4:0] btn_new;

	assign full      = (count_q == fmq_pkg::CntW'(fmq_pkg::QueueDepth));
	assign in_ready  = (state_q == fmq_pkg::ST_IDLE);
	assign res_valid = (state_q == fmq_pkg::ST_DONE);
	assign res_item  = res_q;
	assign count     = count_q;

	always_comb begin
		flag  = 5'd0;
		bcode = 32'd0;
		unique case (fmq_pkg::btn_t'(in_item.button_index))
			fmq_pkg::BTN_LEFT: begin
				flag  = fmq_pkg::FlagLeft;
				bcode = (in_item.operation == fmq_pkg::OP_PRESS) ?
					fmq_pkg::CodeLDown : fmq_pkg::CodeLUp;
			end
			fmq_pkg::BTN_RIGHT: begin
				flag  = fmq_pkg::FlagRight;
				bcode = (in_item.operation == fmq_pkg::OP_PRESS) ?
					fmq_pkg::CodeRDown : fmq_pkg::CodeRUp;
			end
			fmq_pkg::BTN_MIDDLE: begin
				flag  = fmq_pkg::FlagMiddle;
				bcode = (in_item.operation == fmq_pkg::OP_PRESS) ?
					fmq_pkg::CodeMDown : fmq_pkg::CodeMUp;
			end
			default: ;
		endcase
		btn_new = (in_item.operation == fmq_pkg::OP_PRESS) ? (btn_q | flag) :
			(btn_q & ~flag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fmq_pkg::ST_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			quit_q    <= 1'b0;
			btn_q     <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ptr_q     <= ptr_d;
			quit_q    <= quit_d;
			btn_q     <= btn_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (in_valid && in_ready)
			item_q <= in_item;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		quit_d    = quit_q;
		btn_d     = btn_q;
		res_d     = res_q;
		mem_req   = '0;
		new_e     = '0;
		unique case (state_q)
			fmq_pkg::ST_IDLE: begin
				if (in_valid) begin
					res_d = '0;
					state_d = fmq_pkg::ST_DONE;
					new_e.win  = in_item.window_handle;
					new_e.word = in_item.word_param;
					new_e.lng  = in_item.long_param;
					new_e.tim  = in_item.event_time;
					new_e.sx   = in_item.pos_x;
					new_e.sy   = in_item.pos_y;
					mem_req.waddr = count_q[fmq_pkg::IdxW-1:0];
					unique case (fmq_pkg::op_t'(in_item.operation))
						fmq_pkg::OP_POST: begin
							new_e.code = in_item.message_code;
							if (!full) begin
								mem_req.we = 1'b1;
								count_d = count_q + 1'b1;
								res_d.success = 1'b1;
							end
						end
						fmq_pkg::OP_QUIT: begin
							new_e = '0;
							new_e.code = fmq_pkg::CodeQuit;
							if (quit_q)
								res_d.success = 1'b1;
							else if (!full) begin
								mem_req.we = 1'b1;
								count_d = count_q + 1'b1;
								quit_d = 1'b1;
								res_d.success = 1'b1;
							end
						end
						fmq_pkg::OP_MOVE: begin
							btn_d = in_item.button_mask[4:0] &
								(fmq_pkg::FlagLeft | fmq_pkg::FlagRight |
								fmq_pkg::FlagMiddle);
							if (count_q != '0) begin
								// fetch the newest entry to test for coalescing
								mem_req.raddr = fmq_pkg::IdxW'(count_q - 1'b1);
								state_d = fmq_pkg::ST_TAIL;
							end else begin
								new_e.code = fmq_pkg::CodeMove;
								new_e.word = in_item.word_param | 32'(btn_d);
								mem_req.we = 1'b1;
								count_d = count_q + 1'b1;
								res_d.success = 1'b1;
							end
						end
						fmq_pkg::OP_PRESS, fmq_pkg::OP_RELEASE: begin
							if (flag != 5'd0) begin
								btn_d = btn_new;
								new_e.code = bcode;
								new_e.word = in_item.word_param | 32'(btn_new);
								if (!full) begin
									mem_req.we = 1'b1;
									count_d = count_q + 1'b1;
									res_d.success = 1'b1;
								end
							end
						end
						fmq_pkg::OP_PEEK, fmq_pkg::OP_TAKE: begin
							if (count_q != '0) begin
								mem_req.raddr = '0;
								ptr_d = '0;
								state_d = fmq_pkg::ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			fmq_pkg::ST_TAIL: begin
				state_d = fmq_pkg::ST_DONE;
				new_e.win  = item_q.window_handle;
				new_e.code = fmq_pkg::CodeMove;
				new_e.word = item_q.word_param | 32'(btn_q);
				new_e.lng  = item_q.long_param;
				new_e.tim  = item_q.event_time;
				new_e.sx   = item_q.pos_x;
				new_e.sy   = item_q.pos_y;
				mem_req.wdata = new_e;
				if (mem_rdata.win == item_q.window_handle &&
						mem_rdata.code == fmq_pkg::CodeMove) begin
					mem_req.we = 1'b1;
					mem_req.waddr = fmq_pkg::IdxW'(count_q - 1'b1);
					res_d.success = 1'b1;
				end else if (!full) begin
					mem_req.we = 1'b1;
					mem_req.waddr = count_q[fmq_pkg::IdxW-1:0];
					count_d = count_q + 1'b1;
					res_d.success = 1'b1;
				end
			end
			fmq_pkg::ST_SCAN: begin
				// ptr_q holds the index whose data is on mem_rdata
				if (fmq_pkg::entry_match(mem_rdata, item_q.window_handle,
						item_q.code_lo, item_q.code_hi)) begin
					res_d.success      = 1'b1;
					res_d.out_window   = mem_rdata.win;
					res_d.out_code     = mem_rdata.code;
					res_d.out_word     = mem_rdata.word;
					res_d.out_long     = mem_rdata.lng;
					res_d.out_time     = mem_rdata.tim;
					res_d.out_pos_x    = mem_rdata.sx;
					res_d.out_pos_y    = mem_rdata.sy;
					if (item_q.operation == fmq_pkg::OP_TAKE) begin
						if (mem_rdata.code == fmq_pkg::CodeQuit)
							quit_d = 1'b0;
						if (ptr_q + 1'b1 < count_q) begin
							mem_req.raddr = fmq_pkg::IdxW'(ptr_q + 1'b1);
							state_d = fmq_pkg::ST_SHIFT;
						end else begin
							count_d = count_q - 1'b1;
							state_d = fmq_pkg::ST_DONE;
						end
					end else
						state_d = fmq_pkg::ST_DONE;
				end else if (ptr_q + 1'b1 < count_q) begin
					ptr_d = ptr_q + 1'b1;
					mem_req.raddr = fmq_pkg::IdxW'(ptr_q + 1'b1);
				end else
					state_d = fmq_pkg::ST_DONE;
			end
			fmq_pkg::ST_SHIFT: begin
				// mem_rdata holds entry ptr_q+1; move it down one slot
				mem_req.we = 1'b1;
				mem_req.waddr = ptr_q[fmq_pkg::IdxW-1:0];
				mem_req.wdata = mem_rdata;
				ptr_d = ptr_q + 1'b1;
				if (ptr_q + 2'd2 < count_q)
					mem_req.raddr = fmq_pkg::IdxW'(ptr_q + 2'd2);
				else begin
					count_d = count_q - 1'b1;
					state_d = fmq_pkg::ST_DONE;
				end
			end
			fmq_pkg::ST_DONE: begin
				if (res_taken)
					state_d = fmq_pkg::ST_IDLE;
			end
			default: state_d = fmq_pkg::ST_IDLE;
		endcase
		if (state_q == fmq_pkg::ST_IDLE)
			mem_req.wdata = new_e;
	end

endmodule

### rtl/filtered_message_queue.sv
// Sequencing: a post, quit or button item goes from acceptance straight to its result;
// a move first reads the newest entry (state TAIL) when the queue holds one.
// Peek/take: empty gives a result at once, else entries are scanned one per cycle,
// oldest first, until one matches; a take then shifts each later entry down a slot.
// Throughput: one item at a time; the next is accepted once the result has been taken
// and the controller is back in idle, so a scan or shift of a full queue bounds the rate.
// Reset: arst_n clears count, quit flag and button state; entries are undefined.
`include "filtered_message_queue_macros.svh"
module filtered_message_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fmq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fmq_pkg::out_item_t out_data
);

	logic               ready;
	fmq_pkg::mem_req_t  mem_req;
	fmq_pkg::entry_t    mem_rdata;
	logic [fmq_pkg::CntW-1:0] count;

	fmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_item   (in_data),
		.in_ready  (ready),
		.res_valid (out_valid),
		.res_item  (out_data),
		.res_taken (!out_stall),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.count     (count)
	);

	assign in_stall = !ready;

	fmq_ram #(
		.Width (fmq_pkg::EntryW),
		.Depth (fmq_pkg::QueueDepth)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	`FMQ_ASSERT(a_count_range, count <= fmq_pkg::CntW'(fmq_pkg::QueueDepth), "count overflow")
	`FMQ_ASSERT(a_no_overlap, !(out_valid && !in_stall), "accept while result pending")
	`FMQ_ASSERT_PAST(a_count_step, (count == $past(count)) || (count == $past(count) + 1'b1) || (count + 1'b1 == $past(count)), "count jumped")

endmodule

### dv/testbench.sv
module testbench;

	localparam int StallLimit = 20000;
	localparam int HoldCycles = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	fmq_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	fmq_pkg::out_item_t out_data;

	filtered_message_queue dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// predictor state
	fmq_pkg::entry_t q_entries[$];
	logic quit_held;
	logic [4:0] btn_held;
	fmq_pkg::out_item_t pending_results[$];

	int mismatches = 0;
	int idle_cycles = 0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit hold_req = 1'b0;

	function automatic fmq_pkg::out_item_t predict_queue(fmq_pkg::in_item_t it);
		fmq_pkg::out_item_t r;
		fmq_pkg::entry_t e;
		logic [31:0] c;
		logic [4:0] flag;
		logic hit;
		r = '0;
		case (fmq_pkg::op_t'(it.operation))
			fmq_pkg::OP_POST: begin
				if (q_entries.size() < fmq_pkg::QueueDepth) begin
					e = '{it.window_handle, it.message_code, it.word_param,
						it.long_param, it.event_time, it.pos_x, it.pos_y};
					q_entries.push_back(e);
					r.success = 1'b1;
				end
			end
			fmq_pkg::OP_QUIT: begin
				if (quit_held)
					r.success = 1'b1;
				else if (q_entries.size() < fmq_pkg::QueueDepth) begin
					e = '0;
					e.code = fmq_pkg::CodeQuit;
					q_entries.push_back(e);
					quit_held = 1'b1;
					r.success = 1'b1;
				end
			end
			fmq_pkg::OP_MOVE: begin
				btn_held = it.button_mask[4:0] &
					(fmq_pkg::FlagLeft | fmq_pkg::FlagRight | fmq_pkg::FlagMiddle);
				e = '{it.window_handle, fmq_pkg::CodeMove,
					{27'd0, btn_held} | it.word_param,
					it.long_param, it.event_time, it.pos_x, it.pos_y};
				if (q_entries.size() != 0 && q_entries[$].win == it.window_handle
						&& q_entries[$].code == fmq_pkg::CodeMove) begin
					q_entries[$] = e;
					r.success = 1'b1;
				end else if (q_entries.size() < fmq_pkg::QueueDepth) begin
					q_entries.push_back(e);
					r.success = 1'b1;
				end
			end
			fmq_pkg::OP_PRESS, fmq_pkg::OP_RELEASE: begin
				flag = 5'd0;
				c = '0;
				case (fmq_pkg::btn_t'(it.button_index))
					fmq_pkg::BTN_LEFT: begin flag = fmq_pkg::FlagLeft;
						c = (it.operation == fmq_pkg::OP_PRESS) ?
							fmq_pkg::CodeLDown : fmq_pkg::CodeLUp; end
					fmq_pkg::BTN_RIGHT: begin flag = fmq_pkg::FlagRight;
						c = (it.operation == fmq_pkg::OP_PRESS) ?
							fmq_pkg::CodeRDown : fmq_pkg::CodeRUp; end
					fmq_pkg::BTN_MIDDLE: begin flag = fmq_pkg::FlagMiddle;
						c = (it.operation == fmq_pkg::OP_PRESS) ?
							fmq_pkg::CodeMDown : fmq_pkg::CodeMUp; end
					default: ;
				endcase
				if (flag != 5'd0) begin
					if (it.operation == fmq_pkg::OP_PRESS)
						btn_held = btn_held | flag;
					else
						btn_held = btn_held & ~flag;
					if (q_entries.size() < fmq_pkg::QueueDepth) begin
						e = '{it.window_handle, c, {27'd0, btn_held} | it.word_param,
							it.long_param, it.event_time, it.pos_x, it.pos_y};
						q_entries.push_back(e);
						r.success = 1'b1;
					end
				end
			end
			fmq_pkg::OP_PEEK, fmq_pkg::OP_TAKE: begin
				for (int k = 0; k < q_entries.size(); k++) begin
					e = q_entries[k];
					if (e.code == fmq_pkg::CodeQuit)
						hit = 1'b1;
					else if (it.window_handle == fmq_pkg::WinAllOnes && e.win != 0)
						hit = 1'b0;
					else if (it.window_handle != 0 &&
							it.window_handle != fmq_pkg::WinAllOnes &&
							e.win != it.window_handle)
						hit = 1'b0;
					else if (it.code_lo == 0 && it.code_hi == 0)
						hit = 1'b1;
					else
						hit = e.code >= it.code_lo && e.code <= it.code_hi;
					if (hit) begin
						r = '{1'b1, e.win, e.code, e.word, e.lng, e.tim, e.sx, e.sy};
						if (it.operation == fmq_pkg::OP_TAKE) begin
							if (e.code == fmq_pkg::CodeQuit)
								quit_held = 1'b0;
							q_entries.delete(k);
						end
						break;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(fmq_pkg::in_item_t it);
		int gap;
		if (send_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_queue(it));
	endtask

	task automatic send_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_wait();
		send_idle();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic fmq_pkg::in_item_t random_fields(fmq_pkg::op_t op);
		fmq_pkg::in_item_t it;
		it.operation     = op;
		it.window_handle = $urandom;
		it.message_code  = $urandom;
		it.word_param    = $urandom;
		it.long_param    = $urandom;
		it.event_time    = $urandom;
		it.pos_x         = $urandom;
		it.pos_y         = $urandom;
		it.code_lo       = $urandom;
		it.code_hi       = $urandom;
		it.button_mask   = $urandom;
		// keep windows and codes in a small set so filters and coalescing hit
		if ($urandom_range(0, 7) != 0) it.window_handle = $urandom_range(0, 3);
		if ($urandom_range(0, 9) == 0) it.window_handle = fmq_pkg::WinAllOnes;
		if ($urandom_range(0, 3) != 0) it.message_code = $urandom_range(0, 40);
		if ($urandom_range(0, 5) == 0) it.message_code = fmq_pkg::CodeQuit;
		case ($urandom_range(0, 3))
			0: begin it.code_lo = 0; it.code_hi = 0; end
			1: begin it.code_lo = $urandom_range(0, 20);
				it.code_hi = it.code_lo + $urandom_range(0, 600); end
			2: begin it.code_lo = fmq_pkg::CodeMove; it.code_hi = fmq_pkg::CodeMUp; end
			default: ;
		endcase
		it.button_index = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
		return it;
	endfunction

	function automatic fmq_pkg::op_t random_op(int take_bias);
		int v;
		v = $urandom_range(0, 99);
		if (v < 2) return fmq_pkg::OP_NONE;
		if (v < 22) return fmq_pkg::OP_POST;
		if (v < 26) return fmq_pkg::OP_QUIT;
		if (v < 40) return fmq_pkg::OP_MOVE;
		if (v < 50) return fmq_pkg::OP_PRESS;
		if (v < 60) return fmq_pkg::OP_RELEASE;
		if (v < 70 + take_bias / 2) return fmq_pkg::OP_PEEK;
		return fmq_pkg::OP_TAKE;
	endfunction

	// result checking
	always @(posedge clk) begin
		fmq_pkg::out_item_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				x = pending_results.pop_front();
				if (out_data !== x) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", x, out_data);
				end
			end
		end
	end

	// receiver stalling
	always @(posedge clk) begin
		int n;
		if (hold_req) begin
			// hold off for a long stretch while the sender keeps offering
			hold_req = 1'b0;
			out_stall <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			out_stall <= 1'b0;
		end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 16);
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
		end else
			out_stall <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_directed();
		fmq_pkg::in_item_t it;
		it = '0; it.operation = fmq_pkg::OP_PEEK; send_item(it);
		it = '0; it.operation = fmq_pkg::OP_POST; it.window_handle = '1;
		it.message_code = '1; it.word_param = '1; it.long_param = '1; it.event_time = '1;
		it.pos_x = 32'sh8000_0000; it.pos_y = 32'sh7fff_ffff; send_item(it);
		it = '0; it.operation = fmq_pkg::OP_QUIT; send_item(it); send_item(it);
		it = '0; it.operation = fmq_pkg::OP_MOVE; it.window_handle = 5; it.button_mask = '1;
		send_item(it); it.word_param = 32'h100; send_item(it);
		for (int b = 0; b < 4; b++) begin
			it = '0; it.operation = fmq_pkg::OP_PRESS; it.button_index = 2'(b); send_item(it);
			it.operation = fmq_pkg::OP_RELEASE; send_item(it);
		end
		it = '0; it.operation = fmq_pkg::OP_PEEK; it.window_handle = fmq_pkg::WinAllOnes;
		send_item(it);
		it = '0; it.operation = fmq_pkg::OP_TAKE; it.window_handle = 5;
		it.code_lo = fmq_pkg::CodeMove; it.code_hi = fmq_pkg::CodeMove; send_item(it);
		it.code_lo = 32'h9999; it.code_hi = 32'h9999; send_item(it);
		it = '0; it.operation = fmq_pkg::OP_NONE; send_item(it);
		for (int i = 0; i < 8; i++) begin
			it = '0; it.operation = fmq_pkg::OP_TAKE; send_item(it);
		end
		drain_wait();
	endtask

	// fill past depth, including a long receiver hold
	task automatic test_full_queue();
		fmq_pkg::in_item_t it;
		hold_req = 1'b1;
		for (int i = 0; i < fmq_pkg::QueueDepth + 4; i++) begin
			it = random_fields(fmq_pkg::OP_POST);
			send_item(it);
		end
		it = random_fields(fmq_pkg::OP_MOVE); send_item(it);
		it = random_fields(fmq_pkg::OP_PRESS); send_item(it);
		it = random_fields(fmq_pkg::OP_QUIT); send_item(it);
		drain_wait();
		for (int i = 0; i < fmq_pkg::QueueDepth + 2; i++) begin
			it = random_fields(i % 3 == 0 ? fmq_pkg::OP_PEEK : fmq_pkg::OP_TAKE);
			it.window_handle = 0; it.code_lo = 0; it.code_hi = 0;
			send_item(it);
		end
		drain_wait();
	endtask

	task automatic test_random(int count, int take_bias);
		for (int i = 0; i < count; i++) begin
			send_item(random_fields(random_op(take_bias)));
			if (send_idle_on && $urandom_range(0, 199) == 0) drain_wait();
		end
		drain_wait();
	endtask

	initial begin
		quit_held = 1'b0;
		btn_held = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_queue();
		test_random(800, 0);
		test_random(600, 30);
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		test_random(300, 10);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/fmq_pkg.sv
rtl/fmq_ram.sv
rtl/fmq_ctrl.sv
rtl/filtered_message_queue.sv
dv/testbench.sv
